// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that an expression is never true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

// ===== rtl/ase_pkg.sv =====
// Types and constants of the advertising service data extractor.
package ase_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_SERVICE_UUID     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_APPLICATION_CODE = 1'd1;

	// Register reset values
	localparam logic [15:0] SERVICE_UUID_RST     = 16'hFFFA;
	localparam logic [7:0]  APPLICATION_CODE_RST = 8'h0D;

	// Element constants
	localparam logic [7:0] SVC_DATA_TYPE = 8'h16;
	localparam logic [7:0] HDR_BYTES     = 8'd5;

	// Parse phase codes
	localparam int PHASE_W = 3;
	localparam logic [PHASE_W-1:0] PH_LEN  = 3'd0;
	localparam logic [PHASE_W-1:0] PH_TYPE = 3'd1;
	localparam logic [PHASE_W-1:0] PH_ULO  = 3'd2;
	localparam logic [PHASE_W-1:0] PH_UHI  = 3'd3;
	localparam logic [PHASE_W-1:0] PH_APP  = 3'd4;
	localparam logic [PHASE_W-1:0] PH_CNT  = 3'd5;
	localparam logic [PHASE_W-1:0] PH_PAY  = 3'd6;
	localparam logic [PHASE_W-1:0] PH_SKIP = 3'd7;

	typedef struct packed {
		logic [15:0] service_uuid;
		logic [7:0]  application_code;
	} cfg_t;

	typedef struct packed {
		logic [7:0] adv_byte;
		logic [7:0] advert_length;
	} item_t;

endpackage

// ===== rtl/ase_if.sv =====
// Stream interfaces for advertising bytes and extracted results.
interface adv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] adv_byte;
	logic [7:0] advert_length;

	modport source (output valid, output adv_byte, output advert_length, input ready);
	modport sink (input valid, input adv_byte, input advert_length, output ready);
endinterface

interface adv_out_if;
	logic       valid;
	logic       ready;
	logic       found;
	logic [7:0] payload_byte;
	logic       payload_last;
	logic [7:0] payload_length;

	modport source (
		output valid, output found, output payload_byte, output payload_last,
		output payload_length, input ready
	);
	modport sink (
		input valid, input found, input payload_byte, input payload_last,
		input payload_length, output ready
	);
endinterface

// ===== rtl/ase_cfg_regs.sv =====
// Configuration registers of the extractor.
module ase_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ase_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [ase_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output ase_pkg::cfg_t                   cfg
);
	import ase_pkg::*;

	cfg_t cfg_q;

	// Write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.service_uuid     <= SERVICE_UUID_RST;
			cfg_q.application_code <= APPLICATION_CODE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SERVICE_UUID: begin
					cfg_q.service_uuid <= cfg_wdata[15:0];
				end
				REG_APPLICATION_CODE: begin
					cfg_q.application_code <= cfg_wdata[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/ase_in_stage.sv =====
// Input register stage of the extractor.
module ase_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	adv_in_if.sink         adv,
	input  logic           advance,
	output logic           valid_s1,
	output ase_pkg::item_t item_s1
);
	import ase_pkg::*;

	logic  valid_q;
	item_t item_q;
	logic  take;

	// Accept when the stage is empty or drains this cycle
	assign adv.ready = !valid_q || advance;
	assign take      = adv.valid && adv.ready;

	// Hold the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (advance) begin
			valid_q <= 1'b0;
		end
	end

	// Capture the transaction payload
	always_ff @(posedge clk) begin
		if (take) begin
			item_q.adv_byte      <= adv.adv_byte;
			item_q.advert_length <= adv.advert_length;
		end
	end

	assign valid_s1 = valid_q;
	assign item_s1  = item_q;

endmodule

// ===== rtl/ase_parser.sv =====
// Element walker and result register of the extractor.
module ase_parser #(
	parameter int MAX_PAYLOAD = 250
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ase_pkg::cfg_t  cfg,
	input  logic           valid_s1,
	input  ase_pkg::item_t item_s1,
	output logic           advance,
	adv_out_if.source      extract
);
	import ase_pkg::*;

	localparam logic [7:0] MAX_PAY = 8'(MAX_PAYLOAD);

	// Parse state
	logic [7:0]         pos_q, nxt_q, elen_q, ulo_q, rem_q;
	logic [PHASE_W-1:0] phase_q;
	logic               fin_q;

	logic [7:0]         pos_n, nxt_n, elen_n, ulo_n, rem_n;
	logic [PHASE_W-1:0] phase_n, phase_eff;
	logic               fin_n;

	// Result register
	logic       out_valid_q, found_q, last_q;
	logic [7:0] pbyte_q, plen_q;

	logic       consume, last, overrun, qualify, res_valid, res_found, res_last;
	logic [8:0] pos_inc;
	logic [9:0] end_sum;
	logic [7:0] b, pay_len, rem_dec;

	assign advance = !out_valid_q || extract.ready;
	assign consume = valid_s1 && advance;

	assign b       = item_s1.adv_byte;
	assign pos_inc = {1'b0, pos_q} + 9'd1;
	assign last    = pos_inc >= {1'b0, item_s1.advert_length};
	assign end_sum = {1'b0, pos_inc} + {2'b00, b};
	assign overrun = end_sum > {2'b00, item_s1.advert_length};
	assign pay_len = elen_q - HDR_BYTES;
	assign qualify = (b == SVC_DATA_TYPE) && (elen_q > HDR_BYTES) && (pay_len <= MAX_PAY);
	assign rem_dec = (rem_q != 8'd0) ? rem_q - 8'd1 : rem_q;

	// Step the walk by one byte
	always_comb begin
		pos_n     = pos_q;
		nxt_n     = nxt_q;
		elen_n    = elen_q;
		ulo_n     = ulo_q;
		rem_n     = rem_q;
		fin_n     = fin_q;
		res_valid = 1'b0;
		res_found = 1'b0;
		res_last  = 1'b0;
		phase_eff = phase_q;
		if (!fin_q && phase_q == PH_SKIP && pos_q == nxt_q) begin
			phase_eff = PH_LEN;
		end
		phase_n = phase_eff;
		if (!fin_q) begin
			case (phase_eff)
				PH_LEN: begin
					if (last || b == 8'd0 || overrun) begin
						fin_n   = 1'b1;
						phase_n = PH_SKIP;
					end else begin
						elen_n  = b;
						nxt_n   = end_sum[7:0];
						phase_n = PH_TYPE;
					end
				end
				PH_TYPE: begin
					phase_n = qualify ? PH_ULO : PH_SKIP;
				end
				PH_ULO: begin
					ulo_n   = b;
					phase_n = PH_UHI;
				end
				PH_UHI: begin
					phase_n = ({b, ulo_q} == cfg.service_uuid) ? PH_APP : PH_SKIP;
				end
				PH_APP: begin
					phase_n = (b == cfg.application_code) ? PH_CNT : PH_SKIP;
				end
				PH_CNT: begin
					rem_n   = pay_len;
					phase_n = PH_PAY;
				end
				PH_PAY: begin
					res_valid = 1'b1;
					res_found = 1'b1;
					res_last  = (rem_q == 8'd1);
					rem_n     = rem_dec;
					if (rem_dec == 8'd0) begin
						fin_n = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		// Close the advertisement: report no match unless a result or a payload is under way, and restart the walk
		if (last) begin
			if (!res_valid && phase_n != PH_CNT && phase_n != PH_PAY) begin
				res_valid = 1'b1;
			end
			pos_n   = 8'd0;
			nxt_n   = 8'd0;
			elen_n  = 8'd0;
			ulo_n   = 8'd0;
			rem_n   = 8'd0;
			fin_n   = 1'b0;
			phase_n = PH_LEN;
		end else begin
			pos_n = pos_inc[7:0];
		end
	end

	// Advance the parse state on each consumed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= 8'd0;
			nxt_q   <= 8'd0;
			elen_q  <= 8'd0;
			ulo_q   <= 8'd0;
			rem_q   <= 8'd0;
			fin_q   <= 1'b0;
			phase_q <= PH_LEN;
		end else if (consume) begin
			pos_q   <= pos_n;
			nxt_q   <= nxt_n;
			elen_q  <= elen_n;
			ulo_q   <= ulo_n;
			rem_q   <= rem_n;
			fin_q   <= fin_n;
			phase_q <= phase_n;
		end
	end

	// Hold the result valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= consume && res_valid;
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (consume && res_valid) begin
			found_q <= res_found;
			pbyte_q <= res_found ? b : 8'd0;
			last_q  <= res_last;
			plen_q  <= res_found ? pay_len : 8'd0;
		end
	end

	assign extract.valid          = out_valid_q;
	assign extract.found          = found_q;
	assign extract.payload_byte   = pbyte_q;
	assign extract.payload_last   = last_q;
	assign extract.payload_length = plen_q;

endmodule

// ===== rtl/adv_service_data_extractor.sv =====
// Top level of the advertising service data extractor.
//
// channel   dir  payload                                               handshake
// adv       in   adv_byte, advert_length                               valid/ready
// extract   out  found, payload_byte, payload_last, payload_length     valid/ready
// cfg       in   cfg_idx, cfg_wdata                                    cfg_we
//
// One byte is taken per cycle unless the result stalls; it passes the input and result registers.
// The rate is set by the combinational element walk between the input and result registers.
// arst_n clears the walk, the valid flags and loads the register reset values.
// A stalled result stops the walk; the input register still takes one more byte if it is empty.
module adv_service_data_extractor #(
	parameter int MAX_PAYLOAD = 250
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ase_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [ase_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	adv_in_if.sink                          adv,
	adv_out_if.source                       extract
);
	import ase_pkg::*;

`include "assert_macros.svh"

	localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

	cfg_t  cfg;
	logic  valid_s1;
	item_t item_s1;
	logic  advance;
	logic  out_stall;
	logic  nomatch_clean;
	logic  found_len_ok;

	ase_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ase_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	ase_parser #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.advance  (advance),
		.extract  (extract)
	);

	// Terms for the checks below
	assign out_stall     = valid_s1 && extract.valid && !extract.ready;
	assign nomatch_clean = (extract.payload_byte == 8'd0) &&
		(extract.payload_length == 8'd0) && !extract.payload_last;
	assign found_len_ok  = (extract.payload_length != 8'd0) &&
		(extract.payload_length <= MAX_LEN);

	// Input back-pressure only comes from a stalled result with a full input stage
	`ASSERT_CLK(a_ready_low_only_on_stall, clk, arst_n, !adv.ready |-> out_stall, "input stall")
	// A no-match result carries zero payload fields
	`ASSERT_CLK(a_nomatch_zero, clk, arst_n, (extract.valid && !extract.found) |-> nomatch_clean, "no-match payload")
	// A found result reports a payload length within bounds
	`ASSERT_CLK(a_found_len, clk, arst_n, (extract.valid && extract.found) |-> found_len_ok, "payload length")

endmodule

// ===== tb/ase_extract_checker.sv =====
// Checker that predicts the extracted service data stream and compares it with the block.
`timescale 1ns / 100ps
module ase_extract_checker #(
	parameter int MAX_PAYLOAD = 250
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ase_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [ase_pkg::CFG_DATA_W-1:0] cfg_wdata,
	adv_in_if                              adv,
	adv_out_if                             extract,
	output int                             mismatch_count,
	output int                             outstanding
);
	import ase_pkg::*;

	typedef struct packed {
		logic       found;
		logic [7:0] payload_byte;
		logic       payload_last;
		logic [7:0] payload_length;
	} extract_t;

	extract_t expected_extract[$];

	// Own copy of the registers
	logic [15:0] uuid_reg;
	logic [7:0]  app_reg;

	// Own copy of the element walk
	logic [7:0]         byte_pos;
	logic [7:0]         next_hdr;
	logic [7:0]         seg_len;
	logic [7:0]         seg_type;
	logic [7:0]         uuid_lo;
	logic [7:0]         remaining;
	logic [PHASE_W-1:0] phase;
	logic               walk_done;

	int fail_total = 0;
	int pending_total = 0;

	assign mismatch_count = fail_total;
	assign outstanding = pending_total;

	task automatic clear_walk();
		byte_pos = '0;
		next_hdr = '0;
		seg_len = '0;
		seg_type = '0;
		uuid_lo = '0;
		remaining = '0;
		phase = PH_LEN;
		walk_done = 1'b0;
	endtask

	// Advance the walk by one advertising byte and queue the result it causes
	task automatic walk_adv_byte(input logic [7:0] b, input logic [7:0] total);
		logic [7:0] pos;
		logic       at_end;
		logic       emitted;
		extract_t   res;
		pos = byte_pos;
		at_end = (9'(pos) + 9'd1 >= 9'(total));
		emitted = 1'b0;
		res = '0;
		if (!walk_done) begin
			// Resume at the next header once the skipped body is behind us
			if (phase == PH_SKIP && pos == next_hdr)
				phase = PH_LEN;
			case (phase)
				PH_LEN: begin
					if (at_end || b == 8'd0 || 10'(pos) + 10'd1 + 10'(b) > 10'(total)) begin
						walk_done = 1'b1;
						phase = PH_SKIP;
					end else begin
						seg_len = b;
						next_hdr = pos + 8'd1 + b;
						phase = PH_TYPE;
					end
				end
				PH_TYPE: begin
					seg_type = b;
					if (b == SVC_DATA_TYPE && seg_len > HDR_BYTES &&
						int'(seg_len - HDR_BYTES) <= MAX_PAYLOAD)
						phase = PH_ULO;
					else
						phase = PH_SKIP;
				end
				PH_ULO: begin
					uuid_lo = b;
					phase = PH_UHI;
				end
				PH_UHI: begin
					phase = ({b, uuid_lo} == uuid_reg) ? PH_APP : PH_SKIP;
				end
				PH_APP: begin
					phase = (b == app_reg) ? PH_CNT : PH_SKIP;
				end
				PH_CNT: begin
					remaining = seg_len - HDR_BYTES;
					phase = PH_PAY;
				end
				PH_PAY: begin
					res.found = 1'b1;
					res.payload_byte = b;
					res.payload_last = (remaining == 8'd1);
					res.payload_length = seg_len - HDR_BYTES;
					expected_extract.push_back(res);
					emitted = 1'b1;
					if (remaining > 8'd0)
						remaining = remaining - 8'd1;
					if (remaining == 8'd0)
						walk_done = 1'b1;
				end
				default: begin
				end
			endcase
		end
		// Close the advertisement, with a no-match result if nothing was taken
		if (at_end) begin
			if (!emitted && phase != PH_CNT && phase != PH_PAY)
				expected_extract.push_back('0);
			clear_walk();
		end else begin
			byte_pos = pos + 8'd1;
		end
	endtask

	// Compare one result transaction with the oldest expectation
	task automatic check_extract();
		extract_t want;
		if (expected_extract.size() == 0) begin
			$error("unexpected result: found %0d payload_byte 0x%02h",
				extract.found, extract.payload_byte);
			fail_total++;
		end else begin
			want = expected_extract.pop_front();
			if (extract.found !== want.found) begin
				$error("found: expected %0d, actual %0d", want.found, extract.found);
				fail_total++;
			end
			if (extract.payload_byte !== want.payload_byte) begin
				$error("payload_byte: expected 0x%02h, actual 0x%02h",
					want.payload_byte, extract.payload_byte);
				fail_total++;
			end
			if (extract.payload_last !== want.payload_last) begin
				$error("payload_last: expected %0d, actual %0d",
					want.payload_last, extract.payload_last);
				fail_total++;
			end
			if (extract.payload_length !== want.payload_length) begin
				$error("payload_length: expected %0d, actual %0d",
					want.payload_length, extract.payload_length);
				fail_total++;
			end
		end
	endtask

	// Predict on input transactions, track register writes, check output transactions
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uuid_reg = SERVICE_UUID_RST;
			app_reg = APPLICATION_CODE_RST;
			clear_walk();
			expected_extract.delete();
		end else begin
			if (adv.valid && adv.ready)
				walk_adv_byte(adv.adv_byte, adv.advert_length);
			if (cfg_we) begin
				case (cfg_idx)
					REG_SERVICE_UUID:     uuid_reg = cfg_wdata;
					REG_APPLICATION_CODE: app_reg = cfg_wdata[7:0];
					default: begin
					end
				endcase
			end
			if (extract.valid && extract.ready)
				check_extract();
		end
		pending_total = expected_extract.size();
	end

endmodule

// ===== tb/tb_adv_service_data_extractor.sv =====
// Testbench top: drives advertisements and register settings, and gives the verdict.
`timescale 1ns / 100ps
module tb_adv_service_data_extractor;
	import ase_pkg::*;

	localparam int MAX_PAYLOAD = 250;
	localparam int RANDOM_BYTES = 620;
	localparam int CFG_SPACING = 150;
	localparam int SETTLE_CYCLES = 8;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    mismatch_count;
	int                    outstanding;

	adv_in_if  adv_ch ();
	adv_out_if ext_ch ();

	adv_service_data_extractor #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.adv      (adv_ch),
		.extract  (ext_ch)
	);

	ase_extract_checker #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_extract_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_wdata     (cfg_wdata),
		.adv           (adv_ch),
		.extract       (ext_ch),
		.mismatch_count(mismatch_count),
		.outstanding   (outstanding)
	);

	logic [7:0]  adv_frame[$];
	logic [15:0] cur_uuid;
	logic [7:0]  cur_app;
	int          burst_left = 0;
	int          bytes_sent = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Append a service data element: UUID low byte first, code, counter, payload
	function automatic void add_service(input logic [15:0] uuid, input logic [7:0] app,
		input int n);
		adv_frame.push_back(8'(n + 5));
		adv_frame.push_back(SVC_DATA_TYPE);
		adv_frame.push_back(uuid[7:0]);
		adv_frame.push_back(uuid[15:8]);
		adv_frame.push_back(app);
		adv_frame.push_back(8'($urandom));
		repeat (n) adv_frame.push_back(8'($urandom));
	endfunction

	// Append an element of any type with a random body
	function automatic void add_other(input logic [7:0] etype, input int n);
		adv_frame.push_back(8'(n + 1));
		adv_frame.push_back(etype);
		repeat (n) adv_frame.push_back(8'($urandom));
	endfunction

	// Append one random element, mostly matching or near-miss service data
	function automatic void add_random_element();
		int choice;
		int n;
		choice = $urandom_range(0, 5);
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
		if (adv_frame.size() + n + 6 > 250)
			return;
		case (choice)
			0, 1: add_service(cur_uuid, cur_app, n);
			2:    add_service(cur_uuid ^ (16'd1 << $urandom_range(0, 15)), cur_app, n);
			3:    add_service(cur_uuid, cur_app ^ (8'd1 << $urandom_range(0, 7)), n);
			4:    add_other(SVC_DATA_TYPE, $urandom_range(0, 4));
			default: add_other(8'($urandom), $urandom_range(0, 10));
		endcase
	endfunction

	// Build a well-formed advertisement, ended exactly, by zero padding or by an overrun
	function automatic void build_wellformed();
		int k;
		adv_frame.delete();
		repeat ($urandom_range(1, 4)) add_random_element();
		if (adv_frame.size() == 0)
			add_service(cur_uuid, cur_app, 1);
		case ($urandom_range(0, 2))
			1: begin
				adv_frame.push_back(8'd0);
				repeat ($urandom_range(0, 4)) adv_frame.push_back(8'($urandom));
			end
			2: begin
				k = $urandom_range(0, 4);
				adv_frame.push_back(8'($urandom_range(k + 1, 255)));
				repeat (k) adv_frame.push_back(8'($urandom));
			end
			default: begin
			end
		endcase
	endfunction

	// Send one byte as an input transaction; open a random gap between bursts
	task automatic push_byte(input logic [7:0] b, input logic [7:0] total);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				adv_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		adv_ch.valid = 1'b1;
		adv_ch.adv_byte = b;
		adv_ch.advert_length = total;
		@(posedge clk);
		while (!adv_ch.ready) @(posedge clk);
		@(negedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	// Send the frame; bytes from switch_at on carry a second total length
	task automatic send_frame(input logic [7:0] total_a, input int switch_at,
		input logic [7:0] total_b);
		for (int i = 0; i < adv_frame.size(); i++)
			push_byte(adv_frame[i], (i < switch_at) ? total_a : total_b);
	endtask

	task automatic send_whole();
		send_frame(8'(adv_frame.size()), adv_frame.size(), 8'(adv_frame.size()));
	endtask

	// Hold the sender until every expected result has come and the pipeline drains
	task automatic settle();
		adv_ch.valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write both registers on back-to-back cycles
	task automatic set_config(input logic [15:0] uuid, input logic [7:0] app);
		cfg_we = 1'b1;
		cfg_idx = REG_SERVICE_UUID;
		cfg_wdata = uuid;
		@(negedge clk);
		cfg_idx = REG_APPLICATION_CODE;
		cfg_wdata = {8'd0, app};
		@(negedge clk);
		cfg_we = 1'b0;
		cur_uuid = uuid;
		cur_app = app;
	endtask

	// Receiver: stall on a pattern that changes mode every so often
	initial begin
		int stall_mode;
		int mode_left;
		int cyc;
		stall_mode = 0;
		mode_left = 0;
		cyc = 0;
		ext_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			cyc++;
			case (stall_mode)
				0: ext_ch.ready = 1'b1;
				1: ext_ch.ready = 1'($urandom_range(0, 1));
				2: ext_ch.ready = ((cyc % 8) >= 3);
				default: ext_ch.ready = ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// Stop a hung run
	initial begin
		#(10_000_000);
		$display("simulation failed");
		$finish;
	end

	initial begin
		int kind;
		int cfg_mark;
		logic [15:0] new_uuid;
		logic [7:0]  new_app;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_SERVICE_UUID;
		cfg_wdata = '0;
		adv_ch.valid = 1'b0;
		adv_ch.adv_byte = '0;
		adv_ch.advert_length = '0;
		cur_uuid = SERVICE_UUID_RST;
		cur_app = APPLICATION_CODE_RST;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Matching element with three payload bytes, then with a single one
		adv_frame.delete();
		add_service(cur_uuid, cur_app, 3);
		send_whole();
		adv_frame.delete();
		add_service(cur_uuid, cur_app, 1);
		send_whole();

		// Zero length byte stops the walk
		adv_frame = '{8'd0, SVC_DATA_TYPE, 8'hFA};
		send_whole();

		// Element runs past the total length
		adv_frame = '{8'd9, SVC_DATA_TYPE, 8'hFA, 8'hFF, 8'h0D};
		send_whole();

		// Header lands on the last byte, no room for a type
		adv_frame = '{8'd1, 8'hFF, 8'd5};
		send_whole();

		// One-byte advertisement, then bytes with a zero total length
		adv_frame.delete();
		adv_frame.push_back(8'($urandom));
		send_whole();
		adv_frame = '{8'h16, 8'h00, 8'hFF};
		send_frame(8'd0, 3, 8'd0);

		// Service data too short to hold a payload, then a match
		adv_frame.delete();
		add_other(SVC_DATA_TYPE, 4);
		add_service(cur_uuid, cur_app, 2);
		send_whole();

		// Near misses on the UUID low byte, high byte and code
		adv_frame.delete();
		add_service(cur_uuid ^ 16'h0001, cur_app, 2);
		add_service(cur_uuid ^ 16'h8000, cur_app, 2);
		add_service(cur_uuid, cur_app ^ 8'h80, 2);
		send_whole();

		// Other type first; only the first of two matches is taken
		adv_frame.delete();
		add_other(8'h09, 3);
		add_service(cur_uuid, cur_app, 2);
		add_service(cur_uuid, cur_app, 2);
		send_whole();

		// Match followed by zero padding gives no extra result
		adv_frame.delete();
		add_service(cur_uuid, cur_app, 2);
		adv_frame.push_back(8'd0);
		adv_frame.push_back(8'hAA);
		send_whole();

		// Total length shrinks in the middle of the advertisement
		adv_frame.delete();
		add_service(cur_uuid, cur_app, 6);
		send_frame(8'(adv_frame.size()), 3, 8'd4);

		// Register extremes
		settle();
		set_config(16'h0000, 8'h00);
		adv_frame.delete();
		add_service(16'h0000, 8'h00, 2);
		send_whole();
		settle();
		set_config(16'hFFFF, 8'hFF);
		adv_frame.delete();
		add_service(16'hFFFE, 8'hFF, 1);
		add_service(16'hFFFF, 8'hFF, 4);
		send_whole();

		// Largest payload that fits in an advertisement
		adv_frame.delete();
		add_service(cur_uuid, cur_app, 249);
		send_whole();

		// Random advertisements with occasional register changes
		bytes_sent = 0;
		cfg_mark = 0;
		while (bytes_sent < RANDOM_BYTES) begin
			if (bytes_sent - cfg_mark >= CFG_SPACING) begin
				settle();
				case ($urandom_range(0, 3))
					0:       new_uuid = 16'h0000;
					1:       new_uuid = 16'hFFFF;
					2:       new_uuid = SERVICE_UUID_RST;
					default: new_uuid = 16'($urandom);
				endcase
				case ($urandom_range(0, 3))
					0:       new_app = 8'h00;
					1:       new_app = 8'hFF;
					2:       new_app = APPLICATION_CODE_RST;
					default: new_app = 8'($urandom);
				endcase
				set_config(new_uuid, new_app);
				cfg_mark = bytes_sent;
			end
			kind = $urandom_range(0, 19);
			if (kind <= 13) begin
				build_wellformed();
				send_whole();
			end else if (kind <= 15) begin
				// Noise
				adv_frame.delete();
				repeat ($urandom_range(1, 30)) adv_frame.push_back(8'($urandom));
				send_whole();
			end else if (kind <= 17) begin
				// Broken: wrong total, or a total that changes part way
				build_wellformed();
				if ($urandom_range(0, 1) == 0)
					send_frame(8'($urandom_range(1, 255)), adv_frame.size(), 8'd0);
				else
					send_frame(8'(adv_frame.size()), $urandom_range(0, adv_frame.size() - 1),
						8'($urandom_range(1, 255)));
			end else if (kind == 18) begin
				adv_frame.delete();
				repeat ($urandom_range(1, 4)) adv_frame.push_back(8'($urandom));
				send_frame(8'd0, adv_frame.size(), 8'd0);
			end else begin
				adv_frame.delete();
				add_service(cur_uuid, cur_app, $urandom_range(200, 249));
				send_whole();
			end
		end

		// Drain and give the verdict
		adv_ch.valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (2 * SETTLE_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
